[rtl/drc_pkg.sv]
// Shared types and constants for the DRAM RAS/CAS refresh model.
// No dependencies; used by every module of the block.
package drc_pkg;

  localparam int MAX_ROW_BITS = 8;
  localparam int MAX_COL_BITS = 8;
  localparam int DATA_W = 32;
  localparam int TIME_W = 48;
  localparam int ADDR_BUS_W = 8;
  localparam int ROW_W = MAX_ROW_BITS;
  localparam int COL_W = MAX_COL_BITS;
  localparam int CELL_AW = ROW_W + COL_W;
  localparam int ROW_DEPTH = 1 << ROW_W;
  localparam int CELL_DEPTH = 1 << CELL_AW;
  localparam int BITS_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_ADDR_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_ADDR_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 2'd3;

  localparam logic [BITS_W-1:0] DEFAULT_BITS = 6'd8;

  typedef struct packed {
    logic [3:0] row_addr_w;
    logic [3:0] col_addr_w;
    logic [5:0] word_w;
    logic [TIME_W-1:0] refresh_period;
  } cfg_t;

  typedef struct packed {
    logic ras_active;
    logic cas_active;
    logic we_active;
    logic oe_active;
    logic [ADDR_BUS_W-1:0] addr_bus;
    logic [DATA_W-1:0] data_in;
    logic [TIME_W-1:0] now;
  } pins_t;

  typedef struct packed {
    logic refresh;
    logic [ROW_W-1:0] row;
    logic [TIME_W-1:0] now;
    logic [CELL_AW-1:0] cell_addr;
    logic drive;
    logic wr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] dmask;
  } req_t;

  function automatic logic [BITS_W-1:0] eff_bits(logic [BITS_W-1:0] raw,
                                                 logic [BITS_W-1:0] limit);
    logic [BITS_W-1:0] b;
    b = (raw == '0) ? DEFAULT_BITS : raw;
    if (b > limit) b = limit;
    return b;
  endfunction

endpackage

[rtl/dram_ras_cas_refresh_model_core.sv]
// Top level of the asynchronous DRAM RAS/CAS refresh model.
// Depends on drc_pkg, drc_ctrl, drc_cell_mem and drc_refresh.
//
// Usage:
//   s_* channel carries one sample of the control pins, address, data bus
//   and time stamp per item; m_* channel returns one result item per input
//   item, in order: the word read, the bus drive flag and the sticky
//   refresh error flag.
//   cfg_we/cfg_index/cfg_data write the width and refresh period registers;
//   write them only while no item is in flight.
// Pipeline: the accepting cycle decodes the strobes and issues reads of the
//   cell and refresh time memories; the middle stage, when it advances,
//   checks the period, writes both memories back and loads the output
//   register.
// Throughput: one item per cycle unless m_tready stalls; the read of a row or
//   cell written by the item just ahead is served from a forwarding register.
// Reset: clears strobe history, latches, refresh counter, row valid bits
//   and the error flag; registers return to their default values. Cell
//   contents are undefined until written.
// Stall: m_tready low freezes the output register and the middle stage;
//   s_tready drops once both are full.
module dram_ras_cas_refresh_model_core
  import drc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // ras_active, cas_active, we_active, oe_active, addr_bus[7:0],
  // data_in[31:0], now[47:0], zero fill
  input  logic [95:0]           s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // data_out[31:0], drive, refresh_error, zero fill
  output logic [39:0]           m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  pins_t pins;
  req_t req, s1;
  logic s1_valid, s_fire, s1_adv;
  logic [DATA_W-1:0] rdata;
  logic error_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_addr_w <= 4'd8;
      cfg.col_addr_w <= 4'd8;
      cfg.word_w <= 6'd8;
      cfg.refresh_period <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_ADDR_W: cfg.row_addr_w <= cfg_data[3:0];
        REG_COL_ADDR_W: cfg.col_addr_w <= cfg_data[3:0];
        REG_WORD_W: cfg.word_w <= cfg_data[5:0];
        REG_REFRESH_PERIOD: cfg.refresh_period <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pins.ras_active = s_tdata[0];
    pins.cas_active = s_tdata[1];
    pins.we_active = s_tdata[2];
    pins.oe_active = s_tdata[3];
    pins.addr_bus = s_tdata[11:4];
    pins.data_in = s_tdata[43:12];
    pins.now = s_tdata[91:44];
  end

  assign s1_adv = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign s_fire = s_tvalid && s_tready;

  drc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (s_fire),
    .cfg  (cfg),
    .pins (pins),
    .req  (req)
  );

  drc_cell_mem u_cell (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_fire),
    .rd_addr (req.cell_addr),
    .adv     (s1_adv),
    .s1      (s1),
    .rdata   (rdata)
  );

  drc_refresh u_refresh (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (s_fire),
    .rd_row     (req.row),
    .adv        (s1_adv),
    .s1         (s1),
    .period     (cfg.refresh_period),
    .error_next (error_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
    if (s_fire) s1 <= req;
    if (s1_adv) begin
      m_tdata <= {6'b0, error_next, s1.drive,
                  s1.drive ? (rdata & s1.dmask) : {DATA_W{1'b0}}};
    end
  end

endmodule

[rtl/drc_ctrl.sv]
// Pin decode: strobe edge detection, address latches and refresh counter.
// Depends on drc_pkg; produces one memory request per accepted item.
module drc_ctrl
  import drc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  cfg_t  cfg,
  input  pins_t pins,
  output req_t  req
);

  logic [ROW_W-1:0] refresh_counter, refresh_counter_next;
  logic [ROW_W-1:0] latched_row, latched_row_next;
  logic [CELL_AW-1:0] latched_address, latched_address_next;
  logic ras_seen, cas_seen, we_seen;

  logic [BITS_W-1:0] rb, cb, db;
  logic [ROW_W-1:0] row_mask;
  logic [COL_W-1:0] col_mask;
  logic [DATA_W-1:0] dmask;
  logic [ROW_W-1:0] cnt_row;
  logic ras_edge, cas_edge;

  always_comb begin
    rb = eff_bits(BITS_W'(cfg.row_addr_w), BITS_W'(MAX_ROW_BITS));
    cb = eff_bits(BITS_W'(cfg.col_addr_w), BITS_W'(MAX_COL_BITS));
    db = eff_bits(cfg.word_w, BITS_W'(DATA_W));
    row_mask = ROW_W'(((ROW_W+1)'(1) << rb) - (ROW_W+1)'(1));
    col_mask = COL_W'(((COL_W+1)'(1) << cb) - (COL_W+1)'(1));
    dmask = DATA_W'(((DATA_W+1)'(1) << db) - (DATA_W+1)'(1));

    ras_edge = pins.ras_active && !ras_seen;
    cas_edge = pins.cas_active && !cas_seen && pins.ras_active;
    cnt_row = refresh_counter & row_mask;

    latched_row_next = latched_row;
    refresh_counter_next = refresh_counter;
    req.refresh = ras_edge;
    req.row = cnt_row;
    if (ras_edge) begin
      if (!cas_seen) begin
        latched_row_next = ROW_W'(pins.addr_bus) & row_mask;
        req.row = latched_row_next;
      end else begin
        refresh_counter_next = (cnt_row == row_mask) ? '0 : cnt_row + ROW_W'(1);
      end
    end

    latched_address_next = latched_address;
    if (cas_edge) begin
      latched_address_next = (CELL_AW'(latched_row_next & row_mask) << cb)
                           | CELL_AW'(COL_W'(pins.addr_bus) & col_mask);
    end

    req.now = pins.now;
    req.cell_addr = latched_address_next;
    req.drive = pins.cas_active && pins.oe_active;
    req.wr = pins.cas_active && pins.we_active && !we_seen;
    req.wdata = pins.data_in & dmask;
    req.dmask = dmask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_counter <= '0;
      latched_row <= '0;
      latched_address <= '0;
      ras_seen <= 1'b0;
      cas_seen <= 1'b0;
      we_seen <= 1'b0;
    end else if (fire) begin
      refresh_counter <= refresh_counter_next;
      latched_row <= latched_row_next;
      latched_address <= latched_address_next;
      ras_seen <= pins.ras_active;
      cas_seen <= pins.cas_active;
      we_seen <= pins.cas_active && pins.we_active;
    end
  end

endmodule

[rtl/drc_cell_mem.sv]
// Cell array: synchronous read at accept, write back when the item advances.
// Depends on drc_pkg; forwards the most recent write to a matching read.
module drc_cell_mem
  import drc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [CELL_AW-1:0] rd_addr,
  input  logic              adv,
  input  req_t              s1,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] cells [CELL_DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic lw_valid;
  logic [CELL_AW-1:0] lw_addr;
  logic [DATA_W-1:0] lw_data;
  logic wr_en;

  assign wr_en = adv && s1.wr;

  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= cells[rd_addr];
    if (wr_en) cells[s1.cell_addr] <= s1.wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (wr_en) begin
      lw_valid <= 1'b1;
    end
    if (wr_en) begin
      lw_addr <= s1.cell_addr;
      lw_data <= s1.wdata;
    end
  end

  assign rdata = (lw_valid && lw_addr == s1.cell_addr) ? lw_data : mem_q;

endmodule

[rtl/drc_refresh.sv]
// Per-row refresh time store, valid bits, period check and sticky error.
// Depends on drc_pkg; forwards the most recent time write to a matching read.
module drc_refresh
  import drc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ROW_W-1:0]  rd_row,
  input  logic              adv,
  input  req_t              s1,
  input  logic [TIME_W-1:0] period,
  output logic              error_next
);

  logic [TIME_W-1:0] times [ROW_DEPTH];
  logic [ROW_DEPTH-1:0] valid;
  logic [TIME_W-1:0] time_q;
  logic valid_q;
  logic lw_valid;
  logic [ROW_W-1:0] lw_row;
  logic [TIME_W-1:0] lw_time;
  logic error_flag;
  logic wr_en, late;
  logic [TIME_W-1:0] last;

  assign wr_en = adv && s1.refresh;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      time_q <= times[rd_row];
      valid_q <= valid[rd_row];
    end
    if (wr_en) times[s1.row] <= s1.now;
    if (wr_en) begin
      lw_row <= s1.row;
      lw_time <= s1.now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      lw_valid <= 1'b0;
      error_flag <= 1'b0;
    end else if (adv) begin
      if (s1.refresh) begin
        valid[s1.row] <= 1'b1;
        lw_valid <= 1'b1;
      end
      error_flag <= error_next;
    end
  end

  always_comb begin
    if (lw_valid && lw_row == s1.row) last = lw_time;
    else if (valid_q) last = time_q;
    else last = '0;
    late = (s1.now > last) && ((s1.now - last) > period);
    error_next = error_flag || (s1.refresh && late);
  end

endmodule
